// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the bit map RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== hdl/bmrq_pkg.sv =====
// Types, codes and constants of the bit map range query block
package bmrq_pkg;

   localparam int MAX_BITS_DEF  = 4096;
   localparam int WORD_BITS_DEF = 64;

   localparam int OP_W  = 2;
   localparam int IDX_W = 12;
   localparam int CNT_W = 13;

   localparam logic [OP_W-1:0] OP_SET   = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_W-1:0] OP_TEST  = 2'd2;
   localparam logic [OP_W-1:0] OP_ANY   = 2'd3;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_BITS_IN_USE = 1'b0;
   localparam logic [CNT_W-1:0] BITS_IN_USE_RESET = 13'd4096;

   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_INVALID = 1'b1;

   typedef struct packed {
      logic [OP_W-1:0]  opcode;
      logic [IDX_W-1:0] first_bit;
      logic [CNT_W-1:0] range_count;
   } req_payload_type;

   typedef struct packed {
      logic status;
      logic found;
   } rsp_payload_type;

endpackage

// ===== hdl/bmrq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read
module bmrq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/bmrq_split.sv =====
// Splits a bit index into word number and bit offset
module bmrq_split import bmrq_pkg::*; #(
   parameter int DIVISOR = WORD_BITS_DEF,
   parameter int IN_W    = IDX_W,
   parameter int REM_W   = $clog2(WORD_BITS_DEF)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  logic [IN_W-1:0]  dividend,
   output logic             done,
   output logic [IN_W-1:0]  quot,
   output logic [REM_W-1:0] rem
);

   generate
      if ((DIVISOR & (DIVISOR - 1)) == 0) begin : g_shift
         logic             done_ff;
         logic [IN_W-1:0]  quot_ff;
         logic [REM_W-1:0] rem_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= go;
            end
            if (go) begin
               quot_ff <= dividend >> REM_W;
               rem_ff  <= dividend[REM_W-1:0];
            end
         end

         assign done = done_ff;
         assign quot = quot_ff;
         assign rem  = rem_ff;
      end else begin : g_divide
         localparam int SHIFT  = IN_W + REM_W;
         localparam int PROD_W = 2 * IN_W + 1;
         localparam logic [PROD_W-1:0] MULT =
            PROD_W'(((1 << SHIFT) + DIVISOR - 1) / DIVISOR);
         localparam logic [IN_W-1:0] DIV_C = IN_W'(DIVISOR);

         logic              done_ff;
         logic [IN_W-1:0]   quot_ff;
         logic [REM_W-1:0]  rem_ff;
         logic [PROD_W-1:0] prod;
         logic [IN_W-1:0]   quot_calc;
         logic [IN_W-1:0]   back;

         assign prod      = PROD_W'(dividend) * MULT;
         assign quot_calc = IN_W'(prod >> SHIFT);
         assign back      = quot_calc * DIV_C;

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= go;
            end
            if (go) begin
               quot_ff <= quot_calc;
               rem_ff  <= REM_W'(dividend - back);
            end
         end

         assign done = done_ff;
         assign quot = quot_ff;
         assign rem  = rem_ff;
      end
   endgenerate

endmodule

// ===== hdl/bit_map_range_query.sv =====
// Top level of the bit map with set, clear, test and any-set-in-range requests
//
// Requests are taken one at a time: an item is accepted when start is high
// and busy is low, and its single result appears on rsp_payload for one cycle
// with rsp_valid high; the receiver cannot stall it. The flags live in one
// RAM of MAX_BITS/WORD_BITS words, rounded up, with a registered read. Set,
// clear and test go from accept through index split, word read, evaluate
// and write back, and result before the next accept; a range query repeats
// the word read and evaluation for each word the range touches, stopping
// early when a set bit is met. A request with an invalid index or range is
// answered from the idle state without a split or a RAM read, and busy stays
// low. When WORD_BITS is not a power of two, the index split multiplies by a
// constant reciprocal and still registers its result. After reset the block
// clears the RAM one word a cycle, MAX_BITS/WORD_BITS words (64 by default),
// with busy high; register writes are taken during that time.
`include "assert_macros.svh"

module bit_map_range_query import bmrq_pkg::*; #(
   parameter int MAX_BITS  = MAX_BITS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   output rsp_payload_type       rsp_payload,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int OFF_W      = $clog2(WORD_BITS);
   localparam int LIM_MAX    = (MAX_BITS > (1 << CNT_W) - 1) ? (1 << CNT_W) - 1 : MAX_BITS;
   localparam logic [CNT_W-1:0]  LIM_CAP  = CNT_W'(LIM_MAX);
   localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(WORD_COUNT - 1);
   localparam logic [CNT_W-1:0]  WORD_LEN = CNT_W'(WORD_BITS);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SPLIT = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_EVAL  = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [ADDR_W-1:0] word_ff, word_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  bits_in_use_ff, bits_in_use_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_ff, rsp_in;

   logic [CNT_W-1:0]     lim;
   logic [CNT_W-1:0]     idx_ext;
   logic                 req_bad;
   logic                 accept;
   logic                 split_go;
   logic                 split_done;
   logic [IDX_W-1:0]     split_quot;
   logic [OFF_W-1:0]     split_rem;
   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr;
   logic [WORD_BITS-1:0] ram_wdata;
   logic [WORD_BITS-1:0] ram_rdata;
   logic [WORD_BITS-1:0] bit_sel;
   logic [WORD_BITS-1:0] scan_mask;
   logic [CNT_W-1:0]     avail;
   logic                 scan_hit;
   logic                 csr_write;

   assign lim     = (bits_in_use_ff > LIM_CAP) ? LIM_CAP : bits_in_use_ff;
   assign idx_ext = CNT_W'(req_payload.first_bit);
   assign req_bad = (idx_ext >= lim) ||
                    ((req_payload.opcode == OP_ANY) &&
                     ((req_payload.range_count == '0) ||
                      (req_payload.range_count > (lim - idx_ext))));
   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign split_go = accept && !req_bad;

   assign bit_sel = {{(WORD_BITS-1){1'b0}}, 1'b1} << off_ff;
   assign avail   = WORD_LEN - CNT_W'(off_ff);

   always_comb begin
      for (int j = 0; j < WORD_BITS; j++) begin
         scan_mask[j] = (CNT_W'(j) >= CNT_W'(off_ff)) &&
                        ((CNT_W'(j) - CNT_W'(off_ff)) < rem_ff);
      end
   end

   assign scan_hit = |(ram_rdata & scan_mask);

   bmrq_split #(
      .DIVISOR (WORD_BITS),
      .IN_W    (IDX_W),
      .REM_W   (OFF_W)
   ) u_split (
      .clock    (clock),
      .reset    (reset),
      .go       (split_go),
      .dividend (req_payload.first_bit),
      .done     (split_done),
      .quot     (split_quot),
      .rem      (split_rem)
   );

   bmrq_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORD_COUNT)
   ) u_flags (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (word_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = word_ff;
      ram_wdata = ram_rdata | bit_sel;
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = '0;
      end else if (state_ff == ST_EVAL) begin
         ram_we    = (op_ff == OP_SET) || (op_ff == OP_CLEAR);
         ram_wdata = (op_ff == OP_SET) ? (ram_rdata | bit_sel) : (ram_rdata & ~bit_sel);
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      word_in      = word_ff;
      off_in       = off_ff;
      rem_in       = rem_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in  = req_payload.opcode;
               rem_in = req_payload.range_count;
               if (req_bad) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: STATUS_INVALID, found: 1'b0};
               end else begin
                  state_in = ST_SPLIT;
               end
            end
         end
         ST_SPLIT: begin
            if (split_done) begin
               word_in  = ADDR_W'(split_quot);
               off_in   = split_rem;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            unique case (op_ff)
               OP_SET, OP_CLEAR: begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: STATUS_DONE, found: 1'b0};
                  state_in     = ST_IDLE;
               end
               OP_TEST: begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: STATUS_DONE, found: ram_rdata[off_ff]};
                  state_in     = ST_IDLE;
               end
               OP_ANY: begin
                  if (scan_hit || (rem_ff <= avail)) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{status: STATUS_DONE, found: scan_hit};
                     state_in     = ST_IDLE;
                  end else begin
                     rem_in   = rem_ff - avail;
                     off_in   = '0;
                     word_in  = word_ff + 1'b1;
                     state_in = ST_READ;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign csr_write = psel && penable && pwrite && pready &&
                      (paddr[CSR_ADDR_W-1:2] == REG_BITS_IN_USE);
   assign bits_in_use_in = csr_write ? pwdata[CNT_W-1:0] : bits_in_use_ff;
   assign pready = 1'b1;
   assign prdata = (paddr[CSR_ADDR_W-1:2] == REG_BITS_IN_USE) ?
                   CSR_DATA_W'(bits_in_use_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         bits_in_use_ff <= BITS_IN_USE_RESET;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         rsp_valid_ff   <= rsp_valid_in;
         bits_in_use_ff <= bits_in_use_in;
      end
      op_ff   <= op_in;
      word_ff <= word_in;
      off_ff  <= off_in;
      rem_ff  <= rem_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `ASSERT_CLK(a_rsp_source, clock, reset, rsp_valid |-> ($past(state_ff == ST_EVAL) || $past(accept)), "result strobe without an item behind it")
   `ASSERT_NEVER(a_write_idle, clock, reset, ram_we && !busy, "flag RAM written while idle")
   `ASSERT_CLK(a_scan_left, clock, reset, (state_ff == ST_READ && op_ff == OP_ANY) |-> (rem_ff != '0), "range scan reads a word with no bits left")
   `ASSERT_CLK(a_clear_exit, clock, reset, (state_ff == ST_CLEAR) |=> (state_ff == ST_CLEAR || state_ff == ST_IDLE), "clearing pass left to a working state")

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the bit map: set, clear, test and any-set-in-range requests
`timescale 1ns / 1ps

module tb_top import bmrq_pkg::*; ();

   localparam int unsigned CYCLE_LIMIT     = 1_500_000;
   localparam int unsigned PHASE_COUNT     = 12;
   localparam int unsigned ITEMS_PER_PHASE = 155;
   localparam int unsigned TAIL_CYCLES     = 160;
   localparam int unsigned WORD_COUNT      = MAX_BITS_DEF / WORD_BITS_DEF;

   typedef struct packed {
      logic              is_cfg;
      logic [CNT_W-1:0]  cfg_value;
      req_payload_type   item;
      logic              has_literal;
      rsp_payload_type   outcome;
   } script_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_payload_type       req_payload;
   logic                  rsp_valid;
   rsp_payload_type       rsp_payload;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   logic [WORD_BITS_DEF-1:0] shadow_flags [WORD_COUNT];
   logic [CNT_W-1:0]         valid_bit_count;
   rsp_payload_type          expected_outcomes [$];
   script_row_type           script [$];
   int unsigned              failures;
   int unsigned              cycle_count;
   logic                     no_gaps;

   bit_map_range_query uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned usable_bits();
      return (valid_bit_count > MAX_BITS_DEF) ? MAX_BITS_DEF : int'(valid_bit_count);
   endfunction

   function automatic rsp_payload_type apply_request(req_payload_type r);
      rsp_payload_type res;
      int unsigned lim;
      int unsigned idx;
      int unsigned cnt;
      lim = usable_bits();
      idx = r.first_bit;
      cnt = r.range_count;
      res.status = STATUS_DONE;
      res.found  = 1'b0;
      if (idx >= lim) begin
         res.status = STATUS_INVALID;
      end else begin
         unique case (r.opcode)
            OP_SET: begin
               shadow_flags[idx / WORD_BITS_DEF][idx % WORD_BITS_DEF] = 1'b1;
            end
            OP_CLEAR: begin
               shadow_flags[idx / WORD_BITS_DEF][idx % WORD_BITS_DEF] = 1'b0;
            end
            OP_TEST: begin
               res.found = shadow_flags[idx / WORD_BITS_DEF][idx % WORD_BITS_DEF];
            end
            default: begin
               if (cnt == 0 || cnt > lim - idx) begin
                  res.status = STATUS_INVALID;
               end else begin
                  for (int unsigned i = idx; i < idx + cnt; i++) begin
                     if (shadow_flags[i / WORD_BITS_DEF][i % WORD_BITS_DEF]) begin
                        res.found = 1'b1;
                        break;
                     end
                  end
               end
            end
         endcase
      end
      return res;
   endfunction

   function automatic req_payload_type random_request();
      req_payload_type r;
      int unsigned lim;
      int unsigned pick;
      int unsigned idx;
      int unsigned room;
      int unsigned cnt;
      lim  = usable_bits();
      pick = $urandom_range(0, 99);
      r.opcode = (pick < 30) ? OP_SET : (pick < 50) ? OP_CLEAR : (pick < 70) ? OP_TEST : OP_ANY;
      pick = $urandom_range(0, 99);
      if (lim == 0 || pick < 8) begin
         idx = $urandom_range(0, MAX_BITS_DEF - 1);
      end else if (pick < 18) begin
         idx = (lim - 1 + $urandom_range(0, 2)) % MAX_BITS_DEF;
      end else if (pick < 45) begin
         idx = $urandom_range(0, ((lim < 256) ? lim : 256) - 1);
      end else begin
         idx = $urandom_range(0, lim - 1);
      end
      r.first_bit = IDX_W'(idx);
      room = (idx < lim) ? lim - idx : 0;
      pick = $urandom_range(0, 99);
      if (r.opcode != OP_ANY || room == 0 || pick < 10) begin
         cnt = $urandom_range(0, 8191);
      end else if (pick < 20) begin
         cnt = room;
      end else if (pick < 25) begin
         cnt = room + 1;
      end else if (pick < 30) begin
         cnt = 0;
      end else if (pick < 65) begin
         cnt = $urandom_range(1, (room < 70) ? room : 70);
      end else begin
         cnt = $urandom_range(1, room);
      end
      r.range_count = CNT_W'(cnt);
      return r;
   endfunction

   function automatic script_row_type request_row(logic [OP_W-1:0] op, int unsigned idx,
                                                  int unsigned cnt, logic has_literal,
                                                  logic status, logic found);
      script_row_type row;
      row = '0;
      row.item.opcode      = op;
      row.item.first_bit   = IDX_W'(idx);
      row.item.range_count = CNT_W'(cnt);
      row.has_literal      = has_literal;
      row.outcome.status   = status;
      row.outcome.found    = found;
      return row;
   endfunction

   function automatic script_row_type config_row(int unsigned value);
      script_row_type row;
      row = '0;
      row.is_cfg    = 1'b1;
      row.cfg_value = CNT_W'(value);
      return row;
   endfunction

   task automatic wait_idle();
      start = 1'b0;
      while (expected_outcomes.size() != 0 || busy) @(negedge clock);
   endtask

   task automatic write_bits_in_use(input logic [CNT_W-1:0] value);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {REG_BITS_IN_USE, 2'b00};
      pwdata  = CSR_DATA_W'(value);
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      valid_bit_count = value;
      @(negedge clock);
      penable = 1'b0;
      pwrite  = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== CSR_DATA_W'(value)) begin
         $error("bits_in_use readback: expected %0d, got %0d", value, prdata);
         failures++;
      end
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   task automatic issue_request(input req_payload_type item, input logic has_literal,
                                input rsp_payload_type literal_outcome);
      int unsigned     gap;
      logic [31:0]     raw;
      rsp_payload_type outcome;
      gap = no_gaps ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) begin
            raw = $urandom;
            req_payload = raw[$bits(req_payload_type)-1:0];
            @(negedge clock);
         end
      end
      start       = 1'b1;
      req_payload = item;
      do @(posedge clock); while (busy);
      outcome = apply_request(item);
      expected_outcomes.push_back(has_literal ? literal_outcome : outcome);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_outcomes.size() == 0) begin
            $error("result with no item outstanding: status %0d found %0d",
                   rsp_payload.status, rsp_payload.found);
            failures++;
         end else begin
            if (rsp_payload.status !== expected_outcomes[0].status) begin
               $error("status: expected %0d, got %0d", expected_outcomes[0].status,
                      rsp_payload.status);
               failures++;
            end
            if (rsp_payload.found !== expected_outcomes[0].found) begin
               $error("found: expected %0d, got %0d", expected_outcomes[0].found,
                      rsp_payload.found);
               failures++;
            end
            void'(expected_outcomes.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int unsigned value;
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      failures    = 0;
      cycle_count = 0;
      no_gaps     = 1'b0;
      valid_bit_count = BITS_IN_USE_RESET;
      for (int w = 0; w < WORD_COUNT; w++) shadow_flags[w] = '0;

      script.push_back(request_row(OP_TEST,  0,    0,    1'b1, STATUS_DONE,    1'b0));
      script.push_back(request_row(OP_ANY,   0,    4096, 1'b1, STATUS_DONE,    1'b0));
      script.push_back(request_row(OP_SET,   0,    0,    1'b1, STATUS_DONE,    1'b0));
      script.push_back(request_row(OP_SET,   4095, 8191, 1'b1, STATUS_DONE,    1'b0));
      script.push_back(request_row(OP_TEST,  4095, 0,    1'b1, STATUS_DONE,    1'b1));
      script.push_back(request_row(OP_ANY,   0,    0,    1'b1, STATUS_INVALID, 1'b0));
      script.push_back(request_row(OP_ANY,   4095, 1,    1'b1, STATUS_DONE,    1'b1));
      script.push_back(request_row(OP_ANY,   4095, 2,    1'b1, STATUS_INVALID, 1'b0));
      script.push_back(request_row(OP_ANY,   1,    4094, 1'b1, STATUS_DONE,    1'b0));
      script.push_back(request_row(OP_SET,   64,   0,    1'b0, STATUS_DONE,    1'b0));
      script.push_back(request_row(OP_ANY,   1,    63,   1'b1, STATUS_DONE,    1'b0));
      script.push_back(request_row(OP_ANY,   1,    64,   1'b1, STATUS_DONE,    1'b1));
      script.push_back(request_row(OP_ANY,   0,    8191, 1'b1, STATUS_INVALID, 1'b0));
      script.push_back(request_row(OP_CLEAR, 4095, 0,    1'b1, STATUS_DONE,    1'b0));
      script.push_back(request_row(OP_TEST,  4095, 0,    1'b1, STATUS_DONE,    1'b0));
      script.push_back(request_row(OP_CLEAR, 0,    0,    1'b0, STATUS_DONE,    1'b0));
      script.push_back(config_row(100));
      script.push_back(request_row(OP_TEST,  100,  0,    1'b1, STATUS_INVALID, 1'b0));
      script.push_back(request_row(OP_SET,   99,   0,    1'b0, STATUS_DONE,    1'b0));
      script.push_back(request_row(OP_ANY,   64,   36,   1'b0, STATUS_DONE,    1'b0));
      script.push_back(request_row(OP_ANY,   64,   37,   1'b1, STATUS_INVALID, 1'b0));
      script.push_back(request_row(OP_SET,   4095, 0,    1'b1, STATUS_INVALID, 1'b0));
      script.push_back(config_row(0));
      script.push_back(request_row(OP_TEST,  0,    0,    1'b1, STATUS_INVALID, 1'b0));
      script.push_back(request_row(OP_ANY,   0,    1,    1'b1, STATUS_INVALID, 1'b0));
      script.push_back(config_row(8191));
      script.push_back(request_row(OP_TEST,  4095, 0,    1'b0, STATUS_DONE,    1'b0));
      script.push_back(request_row(OP_TEST,  99,   0,    1'b0, STATUS_DONE,    1'b0));

      repeat (6) @(negedge clock);
      reset = 1'b0;

      foreach (script[i]) begin
         if (script[i].is_cfg) begin
            wait_idle();
            write_bits_in_use(script[i].cfg_value);
         end else begin
            issue_request(script[i].item, script[i].has_literal, script[i].outcome);
         end
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         unique case (p)
            0:       value = 4096;
            1:       value = 1;
            2:       value = 4095;
            3:       value = 64;
            4:       value = 65;
            5:       value = 8191;
            6:       value = 4097;
            7:       value = 2;
            8:       value = 0;
            9:       value = $urandom_range(0, 8191);
            default: value = $urandom_range(1, 4096);
         endcase
         wait_idle();
         write_bits_in_use(CNT_W'(value));
         repeat (ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
            issue_request(random_request(), 1'b0, '0);
         end
      end

      start = 1'b0;
      while (expected_outcomes.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/bmrq_pkg.sv
hdl/bmrq_ram.sv
hdl/bmrq_split.sv
hdl/bit_map_range_query.sv
tb/sv/tb_top.sv
